// ===== hdl/btq_pkg.sv =====
// btq_pkg: shared constants, types and codes for the bucketed timer event queue
// no dependencies
`default_nettype none
package btq_pkg;
  localparam int POOL_ENTRIES = 32;
  localparam int NUM_BUCKETS  = 16;
  localparam int TAG_BITS     = 16;
  localparam int SLOT_W = $clog2(POOL_ENTRIES);
  localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_ENTRIES);

  typedef enum logic [1:0] {
    OP_SCHED = 2'd0, OP_CANCEL = 2'd1, OP_POLL = 2'd2, OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NONE_DUE = 2'd1, ST_FULL = 2'd2, ST_NOT_QUEUED = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] pulse;
    logic [31:0] delay;
    logic [15:0] event_tag;
    logic [4:0]  slot;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  out_slot;
    logic [15:0] out_tag;
    logic [31:0] remaining;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_TAIL, S_WALK, S_WR_E, S_WR_PRED, S_WR_SUCC,
    S_UNL_CHK, S_Q_RD, S_OUT
  } fsm_t;
endpackage
`default_nettype wire

// ===== hdl/btq_if.sv =====
// btq_if: valid/ready channel carrying one word
// depends on btq_pkg
`default_nettype none
interface btq_in_if import btq_pkg::*; ();
  logic valid;
  logic ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface btq_out_if import btq_pkg::*; ();
  logic valid;
  logic ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/bucketed_timer_event_queue.sv =====
// bucketed timer event queue, one operation at a time: full pool, unqueued slot or
// empty poll bucket go to S_OUT; query via S_Q_RD, poll not due via S_UNL_CHK;
// cancel and poll pop via S_UNL_CHK, S_WR_PRED, S_WR_SUCC; schedule via S_RD_TAIL,
// S_WALK (one entry per cycle, bucket not empty), S_WR_E, S_WR_PRED, S_WR_SUCC.
// throughput: the next word is taken the cycle after the result word is accepted
// reset: synchronous; clears used bits and bucket heads/tails, entry memory unwritten
// depends on btq_pkg, btq_if, btq_entry_ram
`default_nettype none
module bucketed_timer_event_queue import btq_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  btq_in_if.sink   in_ch,
  btq_out_if.source out_ch
);
  fsm_t st_r, st_nxt;
  in_word_t req_r;
  out_word_t res_r, res_nxt;
  logic [POOL_ENTRIES-1:0] used_r;
  logic [LINK_W-1:0] head_r [NUM_BUCKETS];
  logic [LINK_W-1:0] tail_r [NUM_BUCKETS];

  logic [SLOT_W-1:0] e_r;       // entry being inserted/removed
  logic [31:0] key_r;
  logic [LINK_W-1:0] cur_r;     // entry whose data sits in the read register
  logic [LINK_W-1:0] pred_r, succ_r;  // neighbors of e

  // ram
  logic we_kt, we_next, we_prev;
  logic [SLOT_W-1:0] waddr, raddr;
  logic [31:0] rkey;
  logic [TAG_BITS-1:0] rtag;
  logic [LINK_W-1:0] wnext, wprev, rnext, rprev;
  btq_entry_ram u_ram (.clk, .we_kt, .we_next, .we_prev, .waddr, .wkey(key_r),
    .wtag(req_r.event_tag[TAG_BITS-1:0]), .wnext, .wprev,
    .raddr, .rkey, .rtag, .rnext, .rprev);

  // free slot search and clamped key
  logic [SLOT_W-1:0] free_idx;
  logic free_ok;
  always_comb begin
    free_idx = '0;
    free_ok = 1'b0;
    for (int i = POOL_ENTRIES - 1; i >= 0; i--)
      if (!used_r[i]) begin
        free_idx = SLOT_W'(i);
        free_ok = 1'b1;
      end
  end
  logic [31:0] dly;
  logic [32:0] ksum;
  assign dly  = (in_ch.data.delay[31] || in_ch.data.delay == '0) ? 32'd1
                : in_ch.data.delay;
  assign ksum = {1'b0, in_ch.data.pulse} + {1'b0, dly};

  logic [BKT_W-1:0] bk;
  assign bk = BKT_W'(key_r % NUM_BUCKETS);
  logic [BKT_W-1:0] pbk;
  assign pbk = BKT_W'(in_ch.data.pulse % NUM_BUCKETS);
  logic [BKT_W-1:0] ubk;
  assign ubk = BKT_W'(rkey % NUM_BUCKETS);

  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.data = res_r;

  logic take;
  assign take = in_ch.valid && in_ch.ready;
  logic sched;
  assign sched = (req_r.op == OP_SCHED);
  // walk stops at the first smaller key or at the head
  logic walk_stop;
  assign walk_stop = (rkey < key_r) || (rprev == NIL);
  // poll pops only a due head
  logic unl_go;
  assign unl_go = !(req_r.op == OP_POLL && rkey > req_r.pulse);

  // signed remaining
  logic signed [33:0] rdiff;
  assign rdiff = $signed({2'b0, rkey}) - $signed({2'b0, req_r.pulse});

  always_comb begin
    st_nxt = st_r;
    res_nxt = res_r;
    raddr = cur_r[SLOT_W-1:0];
    we_kt = 1'b0; we_next = 1'b0; we_prev = 1'b0;
    waddr = e_r;
    wnext = succ_r; wprev = pred_r;
    case (st_r)
      S_IDLE: begin
        raddr = (in_ch.data.op == OP_POLL) ? head_r[pbk][SLOT_W-1:0]
                                           : in_ch.data.slot[SLOT_W-1:0];
        if (take) begin
          case (op_t'(in_ch.data.op))
            OP_SCHED: begin
              if (free_ok) st_nxt = S_RD_TAIL;
              else begin
                res_nxt = '{status: ST_FULL, default: '0};
                st_nxt = S_OUT;
              end
            end
            OP_POLL: begin
              if (head_r[pbk] == NIL) begin
                res_nxt = '{status: ST_NONE_DUE, default: '0};
                st_nxt = S_OUT;
              end else st_nxt = S_UNL_CHK;
            end
            default: begin
              if (!used_r[in_ch.data.slot[SLOT_W-1:0]]) begin
                res_nxt = '{status: ST_NOT_QUEUED, out_slot: in_ch.data.slot,
                            default: '0};
                st_nxt = S_OUT;
              end else if (in_ch.data.op == OP_QUERY) st_nxt = S_Q_RD;
              else st_nxt = S_UNL_CHK;
            end
          endcase
        end
      end
      S_RD_TAIL: begin
        raddr = tail_r[bk][SLOT_W-1:0];
        st_nxt = (tail_r[bk] == NIL) ? S_WR_E : S_WALK;
      end
      S_WALK: begin
        if (walk_stop) st_nxt = S_WR_E;
        else raddr = rprev[SLOT_W-1:0];
      end
      S_WR_E: begin
        we_kt = 1'b1; we_next = 1'b1; we_prev = 1'b1;
        waddr = e_r; wnext = succ_r; wprev = pred_r;
        res_nxt = '{status: ST_OK, out_slot: e_r, default: '0};
        st_nxt = S_WR_PRED;
      end
      S_WR_PRED: begin
        we_next = (pred_r != NIL);
        waddr = pred_r[SLOT_W-1:0];
        wnext = sched ? LINK_W'(e_r) : succ_r;
        st_nxt = S_WR_SUCC;
      end
      S_WR_SUCC: begin
        we_prev = (succ_r != NIL);
        waddr = succ_r[SLOT_W-1:0];
        wprev = sched ? LINK_W'(e_r) : pred_r;
        st_nxt = S_OUT;
      end
      S_UNL_CHK: begin
        if (!unl_go) begin
          res_nxt = '{status: ST_NONE_DUE, default: '0};
          st_nxt = S_OUT;
        end else begin
          res_nxt = '{status: ST_OK, out_slot: e_r,
                      out_tag: (req_r.op == OP_POLL) ? 16'(rtag) : 16'd0,
                      remaining: '0};
          st_nxt = S_WR_PRED;
        end
      end
      S_Q_RD: begin
        res_nxt = '{status: ST_OK, out_slot: req_r.slot, out_tag: 16'(rtag),
                    remaining: rdiff > 34'sd2147483647 ? 32'h7fffffff :
                               rdiff < -34'sd2147483648 ? 32'h80000000 :
                               rdiff[31:0]};
        st_nxt = S_OUT;
      end
      S_OUT: if (out_ch.ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      res_r <= '0;
      used_r <= '0;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        head_r[b] <= NIL;
        tail_r[b] <= NIL;
      end
    end else begin
      st_r <= st_nxt;
      res_r <= res_nxt;
      case (st_r)
        S_IDLE: if (take) begin
          req_r <= in_ch.data;
          key_r <= ksum[32] ? 32'hffffffff : ksum[31:0];
          case (op_t'(in_ch.data.op))
            OP_SCHED: e_r <= free_idx;
            OP_POLL: e_r <= head_r[pbk][SLOT_W-1:0];
            default: e_r <= in_ch.data.slot[SLOT_W-1:0];
          endcase
        end
        S_RD_TAIL: begin
          cur_r <= tail_r[bk];
          pred_r <= NIL;
          succ_r <= NIL;
        end
        S_WALK: begin
          if (rkey < key_r) begin
            pred_r <= cur_r;
            succ_r <= rnext;
          end else if (rprev == NIL) begin
            pred_r <= NIL;
            succ_r <= cur_r;
          end else cur_r <= rprev;
        end
        S_WR_E: begin
          used_r[e_r] <= 1'b1;
          if (pred_r == NIL) head_r[bk] <= LINK_W'(e_r);
          if (succ_r == NIL) tail_r[bk] <= LINK_W'(e_r);
        end
        S_UNL_CHK: if (unl_go) begin
          used_r[e_r] <= 1'b0;
          pred_r <= rprev;
          succ_r <= rnext;
          if (rprev == NIL) head_r[ubk] <= rnext;
          if (rnext == NIL) tail_r[ubk] <= rprev;
        end
        default: ;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data));
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid));
  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_WR_E |-> !used_r[e_r]);
  a_unlink_used: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_UNL_CHK |-> used_r[e_r]);
endmodule
`default_nettype wire

// ===== hdl/btq_entry_ram.sv =====
// btq_entry_ram: entry store (key, tag, next, prev), one write and one read port
// per-field write enables; depends on btq_pkg
`default_nettype none
module btq_entry_ram import btq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              we_kt,
  input  wire logic              we_next,
  input  wire logic              we_prev,
  input  wire logic [SLOT_W-1:0] waddr,
  input  wire logic [31:0]       wkey,
  input  wire logic [TAG_BITS-1:0] wtag,
  input  wire logic [LINK_W-1:0] wnext,
  input  wire logic [LINK_W-1:0] wprev,
  input  wire logic [SLOT_W-1:0] raddr,
  output logic      [31:0]       rkey,
  output logic      [TAG_BITS-1:0] rtag,
  output logic      [LINK_W-1:0] rnext,
  output logic      [LINK_W-1:0] rprev
);
  localparam int KW = 32 + TAG_BITS;
  logic [KW-1:0] kt_mem [POOL_ENTRIES];
  logic [LINK_W-1:0] next_mem [POOL_ENTRIES];
  logic [LINK_W-1:0] prev_mem [POOL_ENTRIES];
  logic [KW-1:0] kt_r;
  logic [LINK_W-1:0] next_r, prev_r;

  always_ff @(posedge clk) begin
    if (we_kt) kt_mem[waddr] <= {wkey, wtag};
    if (we_next) next_mem[waddr] <= wnext;
    if (we_prev) prev_mem[waddr] <= wprev;
    kt_r <= kt_mem[raddr];
    next_r <= next_mem[raddr];
    prev_r <= prev_mem[raddr];
  end
  assign {rkey, rtag} = kt_r;
  assign rnext = next_r;
  assign rprev = prev_r;
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// tb: self-checking testbench for the bucketed timer event queue
// drives schedule/cancel/poll/query words and checks every result word
// depends on btq_pkg, btq_if and the block itself
`default_nettype none
module tb;
  import btq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class timer_queue_scoreboard;
    logic [31:0] key_q[POOL_ENTRIES];
    logic [15:0] tag_q[POOL_ENTRIES];
    int unsigned nxt[POOL_ENTRIES];
    int unsigned prv[POOL_ENTRIES];
    bit used[POOL_ENTRIES];
    int unsigned head[NUM_BUCKETS];
    int unsigned tail[NUM_BUCKETS];
    out_word_t pending[$];
    int errors;

    function void clear();
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        used[i] = 0; nxt[i] = POOL_ENTRIES; prv[i] = POOL_ENTRIES;
        key_q[i] = '0; tag_q[i] = '0;
      end
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        head[b] = POOL_ENTRIES; tail[b] = POOL_ENTRIES;
      end
      pending.delete();
      errors = 0;
    endfunction

    function void unlink(int unsigned e);
      int unsigned b, p, n;
      b = key_q[e] % NUM_BUCKETS; p = prv[e]; n = nxt[e];
      if (p == POOL_ENTRIES) head[b] = n; else nxt[p] = n;
      if (n == POOL_ENTRIES) tail[b] = p; else prv[n] = p;
      used[e] = 0;
    endfunction

    function void link(int unsigned e);
      int unsigned b, i;
      b = key_q[e] % NUM_BUCKETS;
      i = tail[b];
      while (i != POOL_ENTRIES && key_q[i] >= key_q[e]) i = prv[i];
      if (i == POOL_ENTRIES) begin
        prv[e] = POOL_ENTRIES; nxt[e] = head[b];
        if (head[b] == POOL_ENTRIES) tail[b] = e; else prv[head[b]] = e;
        head[b] = e;
      end else begin
        prv[e] = i; nxt[e] = nxt[i];
        if (nxt[i] == POOL_ENTRIES) tail[b] = e; else prv[nxt[i]] = e;
        nxt[i] = e;
      end
      used[e] = 1;
    endfunction

    function int unsigned occupancy();
      int unsigned c;
      c = 0;
      for (int i = 0; i < POOL_ENTRIES; i++) c += used[i];
      return c;
    endfunction

    function void note_word(in_word_t w);
      out_word_t r;
      int unsigned e, b, h;
      logic [32:0] k;
      longint diff;
      r = '0;
      case (op_t'(w.op))
        OP_SCHED: begin
          e = POOL_ENTRIES;
          for (int i = POOL_ENTRIES - 1; i >= 0; i--) if (!used[i]) e = i;
          if (e == POOL_ENTRIES) r.status = ST_FULL;
          else begin
            k = {1'b0, w.pulse} + ((w.delay[31] || w.delay == 0) ? 33'd1 : {1'b0, w.delay});
            key_q[e] = k[32] ? 32'hFFFF_FFFF : k[31:0];
            tag_q[e] = w.event_tag;
            link(e);
            r.status = ST_OK; r.out_slot = 5'(e);
          end
        end
        OP_POLL: begin
          b = w.pulse % NUM_BUCKETS; h = head[b];
          if (h != POOL_ENTRIES && key_q[h] <= w.pulse) begin
            r.status = ST_OK; r.out_slot = 5'(h); r.out_tag = tag_q[h];
            unlink(h);
          end else r.status = ST_NONE_DUE;
        end
        default: begin
          r.out_slot = w.slot;
          if (!used[w.slot]) r.status = ST_NOT_QUEUED;
          else if (op_t'(w.op) == OP_CANCEL) unlink(w.slot);
          else begin
            diff = longint'(key_q[w.slot]) - longint'(w.pulse);
            if (diff > 64'sd2147483647) diff = 64'sd2147483647;
            if (diff < -64'sd2147483648) diff = -64'sd2147483648;
            r.out_tag = tag_q[w.slot]; r.remaining = diff[31:0];
          end
        end
      endcase
      pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        report("unexpected word", got.out_slot, 0);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.out_slot !== want.out_slot) report("out_slot", got.out_slot, want.out_slot);
      if (got.out_tag !== want.out_tag) report("out_tag", got.out_tag, want.out_tag);
      if (got.remaining !== want.remaining) report("remaining", got.remaining, want.remaining);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  btq_in_if in_ch ();
  btq_out_if out_ch ();
  bucketed_timer_event_queue dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  timer_queue_scoreboard sb;
  int send_idle = 19;
  int recv_idle = 62;
  int idle_cycles = 0;
  logic [31:0] now_pulse = 0;
  localparam int WATCHDOG = 20000;

  initial begin
    sb = new();
    sb.clear();
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  // receiver side: random stalls, checks on every accepted word
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_word(out_ch.data);
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
      idle_cycles <= idle_cycles + 1;
    else
      idle_cycles <= 0;
    if (idle_cycles >= WATCHDOG) begin
      $display("bucketed_timer_event_queue verification failed");
      $finish;
    end
  end

  // valid stays up into the next word unless the sender idles
  task send_word(in_word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(w);
  endtask

  task send_op(op_t op, logic [31:0] pulse, logic [31:0] delay, logic [15:0] tag,
               logic [4:0] slot);
    in_word_t w;
    w.op = op; w.pulse = pulse; w.delay = delay; w.event_tag = tag; w.slot = slot;
    send_word(w);
  endtask

  // mostly realistic traffic on a slowly advancing clock, with some noise
  task random_word();
    int unsigned pick;
    logic [31:0] d;
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) now_pulse = now_pulse + $urandom_range(3);
    if ($urandom_range(199) == 0) now_pulse = $urandom;
    case ($urandom_range(9))
      0: d = $urandom;
      1: d = 32'h7FFF_FFFF - $urandom_range(3);
      2: d = -$urandom_range(2);
      default: d = $urandom_range(40);
    endcase
    if (pick < 35 && sb.occupancy() < 30)
      send_op(OP_SCHED, now_pulse, d, 16'($urandom), 5'($urandom));
    else if (pick < 45) send_op(OP_SCHED, now_pulse, d, 16'($urandom), 5'($urandom));
    else if (pick < 60) send_op(OP_CANCEL, now_pulse, d, 16'($urandom), 5'($urandom));
    else if (pick < 80) send_op(OP_POLL, now_pulse, d, 16'($urandom), 5'($urandom));
    else send_op(OP_QUERY, (pick < 85) ? $urandom : now_pulse, d, 16'($urandom),
                 5'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: empty queue cases, saturation, equal keys, pool full
    send_op(OP_POLL, 32'd0, 32'd0, 16'd0, 5'd0);
    send_op(OP_QUERY, 32'd0, 32'd0, 16'd0, 5'd31);
    send_op(OP_CANCEL, 32'd0, 32'd0, 16'd0, 5'd0);
    send_op(OP_SCHED, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 5'd31);
    send_op(OP_QUERY, 32'd0, 32'd0, 16'd0, 5'd0);
    send_op(OP_SCHED, 32'd5, 32'h8000_0000, 16'h1234, 5'd0);
    send_op(OP_SCHED, 32'd5, 32'd0, 16'h5678, 5'd0);
    send_op(OP_SCHED, 32'd5, 32'd16, 16'h0001, 5'd0);
    send_op(OP_POLL, 32'd5, 32'd0, 16'd0, 5'd0);
    send_op(OP_POLL, 32'd6, 32'd0, 16'd0, 5'd0);
    send_op(OP_POLL, 32'd6, 32'd0, 16'd0, 5'd0);
    send_op(OP_QUERY, 32'hFFFF_FFFF, 32'd0, 16'd0, 5'd3);
    send_op(OP_QUERY, 32'd0, 32'd0, 16'd0, 5'd3);
    send_op(OP_CANCEL, 32'd0, 32'd0, 16'd0, 5'd3);
    for (int i = 0; i < 32; i++)
      send_op(OP_SCHED, 32'd100, 32'(i % 3 + 1), 16'(i), 5'd0);
    send_op(OP_SCHED, 32'd100, 32'd1, 16'hAAAA, 5'd0);
    for (int i = 0; i < 32; i++) send_op(OP_CANCEL, 32'd0, 32'd0, 16'd0, 5'(i));
    for (int n = 0; n < 1400; n++) begin
      if (n == 470) begin send_idle = 62; recv_idle = 19; end
      if (n == 940) begin send_idle = 0; recv_idle = 0; end
      random_word();
    end
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0)
      $display("bucketed_timer_event_queue verification clean");
    else
      $display("bucketed_timer_event_queue verification failed");
    $finish;
  end
endmodule
`default_nettype wire
